// ===== sv/serial_command_line_parser_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the serial command line parser
// Shared property wrappers: clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_PARSER_TOP_DEFINES_SVH
`define SERIAL_COMMAND_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication
`define SCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scl: same-cycle check failed");

// Next-cycle implication
`define SCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scl: next-cycle check failed");

`endif

// ===== sv/scl_pkg.sv =====
// ---------------------------------------------------------------------------
// scl_pkg
// Types, character codes and sizing constants of the command line parser.
// ---------------------------------------------------------------------------
package scl_pkg;

    // Line buffer sizing: at most LINE_BUFFER_BYTES-1 characters are counted
    localparam int LINE_BUFFER_BYTES = 32;
    localparam int CNT_W             = $clog2(LINE_BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_BUFFER_BYTES - 1);

    // Magnitude saturates at 256
    localparam int MAG_W = 9;
    localparam logic [MAG_W-1:0] MAG_CAP = 9'd256;

    // Register map (index taken from paddr[2])
    localparam int   PADDR_W              = 3;
    localparam logic REG_BRIGHTNESS_LIMIT = 1'b0;
    localparam logic [7:0] LIMIT_RESET    = 8'd20;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_D     = 8'h44;

    // Command kinds, also used as the stored command letter
    typedef enum logic [1:0] {
        KIND_BRIGHT,
        KIND_COLOR,
        KIND_DIGITS
    } kind_t;

    // Parse phases
    typedef enum logic [3:0] {
        PH_START,
        PH_NUM_WS,
        PH_NUM_SIGN,
        PH_NUM_DIG,
        PH_NUM_DONE,
        PH_D_WS1,
        PH_D_WS2,
        PH_D_DONE,
        PH_FAIL
    } phase_t;

    // One parse result, valid when the line gave a command
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] first;
        logic [5:0] second;
    } result_t;

endpackage

// ===== sv/scl_apb_regs.sv =====
// ---------------------------------------------------------------------------
// scl_apb_regs
// APB-style configuration register: brightness limit.
// ---------------------------------------------------------------------------
module scl_apb_regs
    import scl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [7:0]         limit
);

    logic [7:0] limit_reg;
    logic [7:0] limit_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write decode
    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en && (paddr[2] == REG_BRIGHTNESS_LIMIT))
        begin
            limit_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // Read mux; addresses past the map read zero
    assign prdata = (paddr[2] == REG_BRIGHTNESS_LIMIT) ? {24'd0, limit_reg} : 32'd0;
    assign limit  = limit_reg;

endmodule

// ===== sv/scl_line_parser.sv =====
// ---------------------------------------------------------------------------
// scl_line_parser
// Per-byte line state machine; evaluates the line on carriage return.
// ---------------------------------------------------------------------------
module scl_line_parser
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] rx_char,
    input  logic [7:0] limit,
    output result_t    result
);

    phase_t           phase_reg,   phase_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    kind_t            letter_reg,  letter_next;
    logic             neg_reg,     neg_next;
    logic [MAG_W-1:0] mag_reg,     mag_next;
    logic [2:0]       low3_reg,    low3_next;
    logic [3:0]       left_reg,    left_next;
    logic [3:0]       right_reg,   right_next;
    logic             ended_reg,   ended_next;

    logic        is_cr;
    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] mag_x10;
    logic [MAG_W-1:0] mag_acc;
    logic [2:0]  low3_acc;

    // Character classes
    assign is_cr    = (rx_char == CHAR_CR);
    assign is_space = (rx_char == CHAR_SPACE) || ((rx_char >= CHAR_TAB) && (rx_char <= CHAR_CR));
    assign is_digit = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);
    assign digit    = rx_char[3:0];

    // Digit accumulation: magnitude * 10 + d, saturating; low bits follow exact value
    assign mag_x10  = ({3'd0, mag_reg} << 3) + ({3'd0, mag_reg} << 1) + {8'd0, digit};
    assign mag_acc  = (mag_x10 > {3'd0, MAG_CAP}) ? MAG_CAP : mag_x10[MAG_W-1:0];
    assign low3_acc = {low3_reg[1:0], 1'b0} + digit[2:0];

    // Result evaluation from the current line state
    always_comb
    begin
        result        = '0;
        result.kind   = letter_reg;
        if (phase_reg == PH_NUM_DIG || phase_reg == PH_NUM_DONE)
        begin
            result.valid = is_cr;
            case (letter_reg)
                KIND_BRIGHT:
                begin
                    if (neg_reg)
                        result.first = 8'd0;
                    else if (mag_reg > {1'b0, limit})
                        result.first = limit;
                    else
                        result.first = mag_reg[7:0];
                end
                default:
                begin
                    result.first = {5'd0, (neg_reg ? 3'(3'd0 - low3_reg) : low3_reg)};
                end
            endcase
        end
        else if (phase_reg == PH_D_DONE)
        begin
            result.valid  = is_cr;
            result.kind   = KIND_DIGITS;
            result.first  = CHAR_ZERO + {4'd0, left_reg};
            result.second = 6'(CHAR_ZERO) + {2'd0, right_reg};
        end
    end

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        letter_next = letter_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        low3_next   = low3_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        ended_next  = ended_reg;

        if (step_en)
        begin
            if (is_cr)
            begin
                // end of line: back to line start
                phase_next  = PH_START;
                count_next  = '0;
                letter_next = KIND_BRIGHT;
                neg_next    = 1'b0;
                mag_next    = '0;
                low3_next   = '0;
                left_next   = '0;
                right_next  = '0;
                ended_next  = 1'b0;
            end
            else if (count_reg < CNT_MAX)
            begin
                count_next = count_reg + 1'b1;
                if (!ended_reg)
                begin
                    if (rx_char == CHAR_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                if (rx_char == CHAR_B)
                                begin
                                    letter_next = KIND_BRIGHT;
                                    phase_next  = PH_NUM_WS;
                                end
                                else if (rx_char == CHAR_C)
                                begin
                                    letter_next = KIND_COLOR;
                                    phase_next  = PH_NUM_WS;
                                end
                                else if (rx_char == CHAR_D)
                                begin
                                    letter_next = KIND_DIGITS;
                                    phase_next  = PH_D_WS1;
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_NUM_WS:
                            begin
                                if (is_space)
                                begin
                                    phase_next = PH_NUM_WS;
                                end
                                else if (rx_char == CHAR_PLUS || rx_char == CHAR_MINUS)
                                begin
                                    neg_next   = (rx_char == CHAR_MINUS);
                                    phase_next = PH_NUM_SIGN;
                                end
                                else if (is_digit)
                                begin
                                    mag_next   = mag_acc;
                                    low3_next  = low3_acc;
                                    phase_next = PH_NUM_DIG;
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_NUM_SIGN:
                            begin
                                if (is_digit)
                                begin
                                    mag_next   = mag_acc;
                                    low3_next  = low3_acc;
                                    phase_next = PH_NUM_DIG;
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_NUM_DIG:
                            begin
                                if (is_digit)
                                begin
                                    mag_next  = mag_acc;
                                    low3_next = low3_acc;
                                end
                                else
                                begin
                                    phase_next = PH_NUM_DONE;
                                end
                            end
                            PH_D_WS1:
                            begin
                                if (is_digit)
                                begin
                                    left_next  = digit;
                                    phase_next = PH_D_WS2;
                                end
                                else if (!is_space)
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_D_WS2:
                            begin
                                if (is_digit)
                                begin
                                    right_next = digit;
                                    phase_next = PH_D_DONE;
                                end
                                else if (!is_space)
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            count_reg  <= '0;
            letter_reg <= KIND_BRIGHT;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            low3_reg   <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            letter_reg <= letter_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
            low3_reg   <= low3_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

// ===== sv/scl_result_reg.sv =====
// ---------------------------------------------------------------------------
// scl_result_reg
// Output register holding one parse result until the consumer takes it.
// ---------------------------------------------------------------------------
module scl_result_reg
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    result,
    input  logic       out_ready,
    output logic       out_valid,
    output logic       free,
    output logic [1:0] command_kind,
    output logic [7:0] first_value,
    output logic [5:0] second_value
);

    logic       valid_reg,  valid_next;
    logic [1:0] kind_reg,   kind_next;
    logic [7:0] first_reg,  first_next;
    logic [5:0] second_reg, second_next;

    // Slot is free when empty or being drained this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next  = valid_reg && !out_ready;
        kind_next   = kind_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            kind_next   = result.kind;
            first_next  = result.first;
            second_next = result.second;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign out_valid    = valid_reg;
    assign command_kind = kind_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;

endmodule

// ===== sv/serial_command_line_parser_top.sv =====
// ---------------------------------------------------------------------------
// serial_command_line_parser_top
// Parses received bytes into B/C/D commands, one result per good line.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | in_valid / in_ready     | rx_byte
//  output   | out_valid / out_ready   | command_kind, first_value, second_value
//  config   | psel/penable/pwrite/... | paddr, pwdata, prdata (brightness_limit)
//
//  One byte per cycle while no carriage return is held; a result shows once its
//  carriage return is taken and passes the input register, then the result register.
//  The line state updates as each byte leaves the input register.
//  A stalled output holds only a carriage return behind a full result slot;
//  other bytes keep flowing. Reset is asynchronous, active low, no clear pass.
// ---------------------------------------------------------------------------
module serial_command_line_parser_top
    import scl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // byte input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    // result output
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         command_kind,
    output logic [7:0]         first_value,
    output logic [5:0]         second_value,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;
    logic [7:0] limit;
    logic       slot_free;
    logic       step_en;
    result_t    result;

    scl_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    // Byte leaves the input register unless it is a return blocked by the output
    assign step_en  = in_valid_reg && ((in_byte_reg != CHAR_CR) || slot_free);
    assign in_ready = !in_valid_reg || step_en;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
            in_byte_next  = rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    scl_line_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .rx_char (in_byte_reg),
        .limit   (limit),
        .result  (result)
    );

    scl_result_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step_en && result.valid),
        .result       (result),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .free         (slot_free),
        .command_kind (command_kind),
        .first_value  (first_value),
        .second_value (second_value)
    );

endmodule

// ===== sv/scl_checker.sv =====
// ---------------------------------------------------------------------------
// scl_checker
// Port-level checks on the parser's result channel.
// ---------------------------------------------------------------------------
`include "serial_command_line_parser_top_defines.svh"

module scl_checker
    import scl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] command_kind,
    input logic [7:0] first_value,
    input logic [5:0] second_value
);

    logic out_stall;
    logic left_is_digit;
    logic right_is_digit;
    logic no_second;

    // Terms shared by the checks below
    assign out_stall      = out_valid && !out_ready;
    assign left_is_digit  = (first_value >= CHAR_ZERO) && (first_value <= CHAR_NINE);
    assign right_is_digit = (second_value >= 6'(CHAR_ZERO)) && (second_value <= 6'(CHAR_NINE));
    assign no_second      = (first_value[7:3] == 5'd0) && (second_value == 6'd0);

    // A stalled result stays offered, with first and second values unchanged
    `SCL_ASSERT_NEXT(a_out_hold, out_stall, out_valid)
    `SCL_ASSERT_NEXT(a_out_stable, out_stall, $stable(first_value) && $stable(second_value))

    // Display results carry two ASCII digits
    `SCL_ASSERT_NOW(a_digits, out_valid && command_kind == KIND_DIGITS, left_is_digit && right_is_digit)

    // Color results have no second value and fit three bits
    `SCL_ASSERT_NOW(a_color, out_valid && command_kind == KIND_COLOR, no_second)

endmodule

bind serial_command_line_parser_top scl_checker u_scl_checker (.*);
